// File: hdl/mom_pkg.sv
package mom_pkg;

    // set geometry
    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_W    = 8;
    localparam int FRAC_W      = 8;
    localparam int VALUE_W     = SAMPLE_W + FRAC_W;
    localparam int COUNT_W     = 7;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = $clog2(MAX_SAMPLES * ((1 << SAMPLE_W) - 1) + 1);
    localparam int BIT_W       = $clog2(SAMPLE_W);

    // mean divider: (sum << FRAC_W) / count, one quotient bit per cycle
    localparam int DIV_W       = SUM_W + FRAC_W;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    // register port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_USE_MEDIAN = '0;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_DIV_START,
        ST_DIV,
        ST_SEL_HI_START,
        ST_SEL_HI,
        ST_SEL_LO_START,
        ST_SEL_LO,
        ST_LOAD
    } mom_state_t;

    typedef struct packed {
        logic store;
        logic div_start;
        logic div_step;
        logic sel_start;
        logic sel_rank_lo;
        logic sel_step;
        logic load_out;
    } mom_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sel_done;
        logic n_odd;
        logic out_full;
    } mom_status_t;

endpackage

// File: hdl/mom_in_if.sv
interface mom_in_if;

    logic                           valid;
    logic                           ready;
    logic [mom_pkg::SAMPLE_W-1:0]   sample;
    logic                           last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);

endinterface

// File: hdl/mom_out_if.sv
interface mom_out_if;

    logic                           valid;
    logic                           ready;
    logic [mom_pkg::VALUE_W-1:0]    central_value;
    logic [mom_pkg::COUNT_W-1:0]    count;
    logic                           overflow;

    modport source (output valid, output central_value, output count, output overflow,
                    input ready);
    modport sink   (input valid, input central_value, input count, input overflow,
                    output ready);

endinterface

// File: hdl/mom_ctrl.sv
module mom_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    input  logic                use_median,
    input  mom_pkg::mom_status_t status,
    output logic                in_ready,
    output mom_pkg::mom_cmd_t   cmd
);

    mom_pkg::mom_state_t state_reg;
    mom_pkg::mom_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mom_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mom_pkg::ST_COLLECT:
            begin
                if (in_valid && in_last)
                begin
                    state_next = use_median ? mom_pkg::ST_SEL_HI_START
                                            : mom_pkg::ST_DIV_START;
                end
            end
            mom_pkg::ST_DIV_START:
            begin
                state_next = mom_pkg::ST_DIV;
            end
            mom_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = mom_pkg::ST_LOAD;
                end
            end
            mom_pkg::ST_SEL_HI_START:
            begin
                state_next = mom_pkg::ST_SEL_HI;
            end
            mom_pkg::ST_SEL_HI:
            begin
                if (status.sel_done)
                begin
                    state_next = status.n_odd ? mom_pkg::ST_LOAD
                                              : mom_pkg::ST_SEL_LO_START;
                end
            end
            mom_pkg::ST_SEL_LO_START:
            begin
                state_next = mom_pkg::ST_SEL_LO;
            end
            mom_pkg::ST_SEL_LO:
            begin
                if (status.sel_done)
                begin
                    state_next = mom_pkg::ST_LOAD;
                end
            end
            mom_pkg::ST_LOAD:
            begin
                if (!status.out_full)
                begin
                    state_next = mom_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = mom_pkg::ST_COLLECT;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            mom_pkg::ST_COLLECT:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid;
            end
            mom_pkg::ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
            end
            mom_pkg::ST_DIV:
            begin
                cmd.div_step = !status.div_done;
            end
            mom_pkg::ST_SEL_HI_START:
            begin
                cmd.sel_start = 1'b1;
            end
            mom_pkg::ST_SEL_HI:
            begin
                cmd.sel_step = 1'b1;
            end
            mom_pkg::ST_SEL_LO_START:
            begin
                cmd.sel_start   = 1'b1;
                cmd.sel_rank_lo = 1'b1;
            end
            mom_pkg::ST_SEL_LO:
            begin
                cmd.sel_step = 1'b1;
            end
            mom_pkg::ST_LOAD:
            begin
                cmd.load_out = !status.out_full;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/mom_dp.sv
module mom_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mom_pkg::mom_cmd_t               cmd,
    input  logic                            use_median,
    input  logic [mom_pkg::SAMPLE_W-1:0]    sample,
    input  logic                            out_ready,
    output mom_pkg::mom_status_t            status,
    output logic                            out_valid,
    output logic [mom_pkg::VALUE_W-1:0]     central_value,
    output logic [mom_pkg::COUNT_W-1:0]     count,
    output logic                            overflow
);

    // sample memory
    logic [mom_pkg::SAMPLE_W-1:0] mem [mom_pkg::MAX_SAMPLES];
    logic [mom_pkg::SAMPLE_W-1:0] rdata_reg;

    // set accumulation
    logic [mom_pkg::CNT_W-1:0]    n_reg,       n_next;
    logic [mom_pkg::SUM_W-1:0]    sum_reg,     sum_next;
    logic                         drop_reg,    drop_next;
    logic                         full;

    // divider
    logic [mom_pkg::DIV_W-1:0]     dq_reg,      dq_next;
    logic [mom_pkg::CNT_W-1:0]     rem_reg,     rem_next;
    logic [mom_pkg::DIV_CNT_W-1:0] dcnt_reg,    dcnt_next;
    logic [mom_pkg::CNT_W:0]       trial;
    logic                          qbit;

    // radix selection
    logic [mom_pkg::BIT_W-1:0]     bit_reg,     bit_next;
    logic [mom_pkg::SAMPLE_W-1:0]  prefix_reg,  prefix_next;
    logic [mom_pkg::SAMPLE_W-1:0]  hi_reg,      hi_next;
    logic [mom_pkg::CNT_W-1:0]     krem_reg,    krem_next;
    logic [mom_pkg::CNT_W-1:0]     zcnt_reg,    zcnt_next;
    logic [mom_pkg::CNT_W-1:0]     addr_reg,    addr_next;
    logic                          rdv_reg,     rdv_next;
    logic [mom_pkg::BIT_W:0]       up_sh;
    logic                          hit;
    logic                          pass_end;
    logic                          take_one;

    // result buffer
    logic                          ov_reg,      ov_next;
    logic [mom_pkg::VALUE_W-1:0]   val_reg;
    logic [mom_pkg::COUNT_W-1:0]   cnt_out_reg;
    logic                          ovf_out_reg;
    logic [mom_pkg::VALUE_W-1:0]   result;
    logic [mom_pkg::SAMPLE_W:0]    mid_sum;

    assign full = (n_reg == mom_pkg::CNT_W'(mom_pkg::MAX_SAMPLES));

    // divider step: shift in one dividend bit, subtract when it fits
    assign trial = {rem_reg, dq_reg[mom_pkg::DIV_W-1]};
    assign qbit  = (trial >= {1'b0, n_reg});

    // selection: element matches prefix above the bit under test and has a zero there
    assign up_sh    = {1'b0, bit_reg} + 1'b1;
    assign hit      = rdv_reg && ((rdata_reg >> up_sh) == (prefix_reg >> up_sh))
                      && !rdata_reg[bit_reg];
    assign pass_end = (addr_reg == n_reg) && !rdv_reg;
    assign take_one = (krem_reg >= zcnt_reg);

    // median of an even set is the mean of the two middle elements
    assign mid_sum = {1'b0, hi_reg} + {1'b0, prefix_reg};

    always_comb
    begin
        if (!use_median)
        begin
            result = dq_reg[mom_pkg::VALUE_W-1:0];
        end
        else if (n_reg[0])
        begin
            result = {prefix_reg, {mom_pkg::FRAC_W{1'b0}}};
        end
        else
        begin
            result = {mid_sum, {(mom_pkg::FRAC_W - 1){1'b0}}};
        end
    end

    // next values of control state
    always_comb
    begin
        n_next      = n_reg;
        sum_next    = sum_reg;
        drop_next   = drop_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        bit_next    = bit_reg;
        prefix_next = prefix_reg;
        hi_next     = hi_reg;
        krem_next   = krem_reg;
        zcnt_next   = zcnt_reg;
        addr_next   = addr_reg;
        rdv_next    = rdv_reg;
        ov_next     = ov_reg;

        // sample transfer: store or drop
        if (cmd.store)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                n_next   = n_reg + 1'b1;
                sum_next = sum_reg + mom_pkg::SUM_W'(sample);
            end
        end

        // divider
        if (cmd.div_start)
        begin
            dq_next   = {sum_reg, {mom_pkg::FRAC_W{1'b0}}};
            rem_next  = '0;
            dcnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            dq_next   = {dq_reg[mom_pkg::DIV_W-2:0], qbit};
            rem_next  = qbit ? mom_pkg::CNT_W'(trial - {1'b0, n_reg})
                             : mom_pkg::CNT_W'(trial);
            dcnt_next = dcnt_reg + 1'b1;
        end

        // selection
        if (cmd.sel_start)
        begin
            bit_next    = mom_pkg::BIT_W'(mom_pkg::SAMPLE_W - 1);
            prefix_next = '0;
            zcnt_next   = '0;
            addr_next   = '0;
            rdv_next    = 1'b0;
            krem_next   = cmd.sel_rank_lo ? (n_reg >> 1) - 1'b1 : (n_reg >> 1);
            if (cmd.sel_rank_lo)
            begin
                hi_next = prefix_reg;
            end
        end
        else if (cmd.sel_step)
        begin
            if (pass_end)
            begin
                // resolve one result bit and restart the scan
                if (take_one)
                begin
                    prefix_next = prefix_reg | (mom_pkg::SAMPLE_W'(1) << bit_reg);
                    krem_next   = krem_reg - zcnt_reg;
                end
                bit_next  = bit_reg - 1'b1;
                addr_next = '0;
                zcnt_next = '0;
                rdv_next  = 1'b0;
            end
            else
            begin
                if (addr_reg != n_reg)
                begin
                    addr_next = addr_reg + 1'b1;
                    rdv_next  = 1'b1;
                end
                else
                begin
                    rdv_next = 1'b0;
                end
                if (hit)
                begin
                    zcnt_next = zcnt_reg + 1'b1;
                end
            end
        end

        // result buffer and set clear
        if (cmd.load_out)
        begin
            ov_next   = 1'b1;
            n_next    = '0;
            sum_next  = '0;
            drop_next = 1'b0;
        end
        else if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= '0;
            sum_reg    <= '0;
            drop_reg   <= 1'b0;
            dq_reg     <= '0;
            rem_reg    <= '0;
            dcnt_reg   <= '0;
            bit_reg    <= '0;
            prefix_reg <= '0;
            hi_reg     <= '0;
            krem_reg   <= '0;
            zcnt_reg   <= '0;
            addr_reg   <= '0;
            rdv_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            n_reg      <= n_next;
            sum_reg    <= sum_next;
            drop_reg   <= drop_next;
            dq_reg     <= dq_next;
            rem_reg    <= rem_next;
            dcnt_reg   <= dcnt_next;
            bit_reg    <= bit_next;
            prefix_reg <= prefix_next;
            hi_reg     <= hi_next;
            krem_reg   <= krem_next;
            zcnt_reg   <= zcnt_next;
            addr_reg   <= addr_next;
            rdv_reg    <= rdv_next;
            ov_reg     <= ov_next;
        end
    end

    // memory write and registered read, result payload
    always_ff @(posedge clk)
    begin
        if (cmd.store && !full)
        begin
            mem[n_reg[mom_pkg::IDX_W-1:0]] <= sample;
        end
        if (cmd.sel_step && !pass_end && (addr_reg != n_reg))
        begin
            rdata_reg <= mem[addr_reg[mom_pkg::IDX_W-1:0]];
        end
        if (cmd.load_out)
        begin
            val_reg     <= result;
            cnt_out_reg <= mom_pkg::COUNT_W'(n_reg);
            ovf_out_reg <= drop_reg;
        end
    end

    assign status.div_done = (dcnt_reg == mom_pkg::DIV_CNT_W'(mom_pkg::DIV_W));
    assign status.sel_done = pass_end && (bit_reg == '0);
    assign status.n_odd    = n_reg[0];
    assign status.out_full = ov_reg;

    assign out_valid     = ov_reg;
    assign central_value = val_reg;
    assign count         = cnt_out_reg;
    assign overflow      = ovf_out_reg;

endmodule

// File: hdl/mean_or_median_of_set.sv
// samples: one transfer per cycle while a set is collected, store write is single cycle
// mean: after the last sample, states DIV_START, DIV and LOAD; one quotient bit per cycle
// median: one memory read port scanned once per result bit; an even set runs a second
// selection for the lower middle element
// a finished result waits in the output register while the next set is collected
// reset: asynchronous, active low; clears set count, sum, overflow, mode and output valid
module mean_or_median_of_set (
    input  logic                            clk,
    input  logic                            rst_n,
    mom_in_if.sink                          samples,
    mom_out_if.source                       results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mom_pkg::PADDR_W-1:0]     paddr,
    input  logic [mom_pkg::PDATA_W-1:0]     pwdata,
    output logic [mom_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    logic                         use_median_reg;
    logic                         use_median_next;
    logic [mom_pkg::REG_IDX_W-1:0] reg_idx;
    mom_pkg::mom_cmd_t            cmd;
    mom_pkg::mom_status_t         status;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[mom_pkg::PADDR_W-1:2];

    always_comb
    begin
        use_median_next = use_median_reg;
        if (psel && penable && pwrite && (reg_idx == mom_pkg::REG_USE_MEDIAN))
        begin
            use_median_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_median_reg <= 1'b0;
        end
        else
        begin
            use_median_reg <= use_median_next;
        end
    end

    assign prdata = (reg_idx == mom_pkg::REG_USE_MEDIAN)
                    ? mom_pkg::PDATA_W'(use_median_reg) : '0;

    // sequencer
    mom_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (samples.valid),
        .in_last    (samples.last),
        .use_median (use_median_reg),
        .status     (status),
        .in_ready   (samples.ready),
        .cmd        (cmd)
    );

    // store, divider, selection and result buffer
    mom_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .use_median    (use_median_reg),
        .sample        (samples.sample),
        .out_ready     (results.ready),
        .status        (status),
        .out_valid     (results.valid),
        .central_value (results.central_value),
        .count         (results.count),
        .overflow      (results.overflow)
    );

endmodule
